>>> sv/spsq_pkg.sv
// Package for the servo drive power sequencer: request, response, configuration
// and sequencer state types, control and status word constants and phase encoding.
// No dependencies.
package spsq_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_WAIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_STEP = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_CODE = 2'd2;

   localparam logic [31:0] RESET_WAIT_DEFAULT = 32'd10000;
   localparam logic [30:0] POS_STEP_DEFAULT = 31'd20000;
   localparam logic signed [7:0] MODE_CODE_DEFAULT = 8'sd8;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_MOVE = 2'd2;

   localparam logic [15:0] CW_SHUTDOWN = 16'h0006;
   localparam logic [15:0] CW_SWITCH_ON = 16'h0007;
   localparam logic [15:0] CW_ENABLE = 16'h000F;
   localparam logic [15:0] CW_FAULT_RESET = 16'h0080;
   localparam logic [15:0] CW_SET_POINT = 16'h001F;

   localparam logic [15:0] SW_READY = 16'h0011;
   localparam logic [15:0] SW_ON = 16'h0037;
   localparam logic [15:0] SW_ACK = 16'h1000;
   localparam logic [15:0] SW_REACHED = 16'h0400;

   localparam logic [3:0] PH_CODE_IDLE = 4'd0;
   localparam logic [3:0] PH_CODE_START = 4'd1;
   localparam logic [3:0] PH_CODE_RESET = 4'd2;
   localparam logic [3:0] PH_CODE_PREPARE = 4'd3;
   localparam logic [3:0] PH_CODE_SWON = 4'd4;
   localparam logic [3:0] PH_CODE_ON = 4'd5;
   localparam logic [3:0] PH_CODE_SETMODE = 4'd6;
   localparam logic [3:0] PH_CODE_SETPOS = 4'd7;
   localparam logic [3:0] PH_CODE_MOVE = 4'd8;

   typedef enum logic [8:0] {
      PH_IDLE    = 9'b000000001,
      PH_START   = 9'b000000010,
      PH_RESET   = 9'b000000100,
      PH_PREPARE = 9'b000001000,
      PH_SWON    = 9'b000010000,
      PH_ON      = 9'b000100000,
      PH_SETMODE = 9'b001000000,
      PH_SETPOS  = 9'b010000000,
      PH_MOVE    = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] drive_status;
      logic [31:0] now_us;
   } req_type;

   typedef struct packed {
      logic [15:0]        drive_control;
      logic signed [31:0] drive_target;
      logic signed [7:0]  drive_mode;
      logic [3:0]         phase;
   } rsp_type;

   typedef struct packed {
      logic [31:0]       reset_wait_us;
      logic [30:0]       position_step;
      logic signed [7:0] cyclic_mode_code;
   } cfg_type;

   typedef struct packed {
      phase_type         seq_phase;
      logic [31:0]       start_stamp;
      logic [15:0]       held_control;
      logic [31:0]       held_target;
      logic signed [7:0] held_mode;
   } seq_state_type;

   function automatic logic [3:0] phase_code(input phase_type ph);
      logic [3:0] code;
      code = PH_CODE_IDLE;
      unique case (ph)
         PH_IDLE:    code = PH_CODE_IDLE;
         PH_START:   code = PH_CODE_START;
         PH_RESET:   code = PH_CODE_RESET;
         PH_PREPARE: code = PH_CODE_PREPARE;
         PH_SWON:    code = PH_CODE_SWON;
         PH_ON:      code = PH_CODE_ON;
         PH_SETMODE: code = PH_CODE_SETMODE;
         PH_SETPOS:  code = PH_CODE_SETPOS;
         PH_MOVE:    code = PH_CODE_MOVE;
         default:    code = PH_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

>>> sv/spsq_csr.sv
// Configuration registers of the servo drive power sequencer.
// Depends on spsq_pkg.
module spsq_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [spsq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [spsq_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output spsq_pkg::cfg_type                   cfg
);
   import spsq_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_RESET_WAIT: cfg_in.reset_wait_us = csr_wdata;
            CSR_POS_STEP:   cfg_in.position_step = csr_wdata[30:0];
            CSR_MODE_CODE:  cfg_in.cyclic_mode_code = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_wait_us <= RESET_WAIT_DEFAULT;
         cfg_ff.position_step <= POS_STEP_DEFAULT;
         cfg_ff.cyclic_mode_code <= MODE_CODE_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/spsq_step.sv
// Next-state logic of the sequencer for one control cycle request.
// Depends on spsq_pkg.
module spsq_step (
   input  spsq_pkg::req_type        req,
   input  spsq_pkg::cfg_type        cfg,
   input  spsq_pkg::seq_state_type  cur,
   output spsq_pkg::seq_state_type  nxt
);
   import spsq_pkg::*;

   phase_type   entry_phase;
   logic [31:0] elapsed;

   assign elapsed = req.now_us - cur.start_stamp;

   always_comb begin
      priority if (req.cmd == CMD_START) begin
         entry_phase = PH_START;
      end else if (req.cmd == CMD_MOVE) begin
         entry_phase = PH_SETMODE;
      end else begin
         entry_phase = cur.seq_phase;
      end
   end

   always_comb begin
      nxt = cur;
      nxt.seq_phase = entry_phase;
      unique case (entry_phase)
         PH_START: begin
            nxt.start_stamp = req.now_us;
            nxt.held_control = CW_FAULT_RESET;
            nxt.seq_phase = PH_RESET;
         end
         PH_RESET: begin
            nxt.held_control = CW_SHUTDOWN;
            if (elapsed > cfg.reset_wait_us) begin
               nxt.seq_phase = PH_PREPARE;
            end
         end
         PH_PREPARE: begin
            nxt.held_control = CW_SWITCH_ON;
            if ((req.drive_status & SW_READY) == SW_READY) begin
               nxt.seq_phase = PH_SWON;
            end
         end
         PH_SWON: begin
            nxt.held_control = CW_ENABLE;
            if ((req.drive_status & SW_ON) == SW_ON) begin
               nxt.seq_phase = PH_ON;
            end
         end
         PH_ON: begin
            nxt.seq_phase = PH_IDLE;
         end
         PH_SETMODE: begin
            nxt.held_target = '0;
            nxt.held_mode = cfg.cyclic_mode_code;
            nxt.seq_phase = PH_SETPOS;
         end
         PH_SETPOS: begin
            nxt.held_target = cur.held_target + {1'b0, cfg.position_step};
            if ((req.drive_status & SW_ACK) != '0) begin
               nxt.seq_phase = PH_MOVE;
            end
         end
         PH_MOVE: begin
            nxt.held_control = CW_SET_POINT;
            if ((req.drive_status & SW_REACHED) != '0) begin
               nxt.held_control = CW_ENABLE;
               nxt.seq_phase = PH_SETPOS;
            end
         end
         default: begin
            nxt.seq_phase = entry_phase;
         end
      endcase
   end

endmodule

>>> sv/servo_drive_power_sequencer_core.sv
// Top level of the servo drive power sequencer: request register, sequencer
// state, response register and configuration. Depends on spsq_pkg, spsq_csr, spsq_step.
//
// One request is taken per clock unless the response side stalls, and every request yields exactly one response.
// A request is captured in the input register, the sequencer step is evaluated
// from that register and the response is loaded into the output register when
// the output register is free or being emptied. Throughput is one request per
// cycle as long as the response side keeps taking responses; a stall on the
// response side backs up through the two registers. Configuration
// registers take effect on the next request evaluated and should be written only
// while no request is in flight.
module servo_drive_power_sequencer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  spsq_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output spsq_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write_en,
   input  logic [spsq_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [spsq_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import spsq_pkg::*;

   cfg_type       cfg;
   req_type       req_ff;
   logic          req_valid_ff;
   logic          req_valid_in;
   seq_state_type state_ff;
   seq_state_type state_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          advance;
   logic          take;

   spsq_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   spsq_step u_step (
      .req (req_ff),
      .cfg (cfg),
      .cur (state_ff),
      .nxt (state_in)
   );

   assign advance = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign take = req_valid && req_ready;

   assign req_valid_in = take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      rsp_in.drive_control = state_in.held_control;
      rsp_in.drive_target = state_in.held_target;
      rsp_in.drive_mode = state_in.held_mode;
      rsp_in.phase = phase_code(state_in.seq_phase);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff.seq_phase <= PH_IDLE;
         state_ff.start_stamp <= '0;
         state_ff.held_control <= '0;
         state_ff.held_target <= '0;
         state_ff.held_mode <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
